>>> hw/rtl/mtd_pkg.sv
package mtd_pkg;

  // defaults for the top-level parameters
  localparam int TAPS_DEF  = 4;
  localparam int DEPTH_DEF = 4096;

  // field widths
  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int DELAY_W   = 12;
  localparam int BUFLEN_W  = 12;
  localparam int NTAPS_W   = 3;
  localparam int CFG_W     = 28;
  localparam int CFG_IDX_W = 3;

  // datapath widths: sample x Q2.14 gain, sum of up to four, times Q2.14 master
  localparam int PROD_W  = SAMPLE_W + GAIN_W + 1;
  localparam int ACC_W   = PROD_W + 2;
  localparam int TOTAL_W = ACC_W + GAIN_W + 1;
  localparam int FRAC_SH = 28;
  localparam int Q_W     = TOTAL_W - FRAC_SH;

  // tap setting layout
  localparam int TAP_DLY_LSB = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUFFER_LENGTH = 3'd0,
    REG_ACTIVE_TAPS   = 3'd1,
    REG_MIX_GAIN      = 3'd2,
    REG_TAP0          = 3'd3,
    REG_TAP1          = 3'd4,
    REG_TAP2          = 3'd5,
    REG_TAP3          = 3'd6
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_TAP,
    S_DRAIN,
    S_DONE
  } state_t;

  // controls from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic              start;
    logic              tap_vld;
    logic              tap_fwd;
    logic              tap_live;
    logic [GAIN_W-1:0] tap_gain;
    logic              master_en;
  } mac_ctrl_t;

endpackage

>>> hw/rtl/mtd_ram.sv
module mtd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/mtd_mac.sv
module mtd_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mtd_pkg::mac_ctrl_t                  ctrl,
  input  logic signed [mtd_pkg::SAMPLE_W-1:0] sample,
  input  logic        [mtd_pkg::SAMPLE_W-1:0] rd_data,
  input  logic        [mtd_pkg::GAIN_W-1:0]   mix_gain,
  output logic                                busy,
  output logic signed [mtd_pkg::SAMPLE_W-1:0] result
);

  import mtd_pkg::*;

  logic                      s1_v_r;
  logic                      s1_fwd_r;
  logic                      s1_live_r;
  logic [GAIN_W-1:0]         s1_gain_r;
  logic                      s2_v_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [SAMPLE_W-1:0] op;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [TOTAL_W-1:0] total_r;
  logic signed [TOTAL_W-1:0] total_nxt;
  logic signed [Q_W-1:0]     q;

  // stage 1: tap qualifiers wait for the registered memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= ctrl.tap_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_fwd_r  <= ctrl.tap_fwd;
    s1_live_r <= ctrl.tap_live;
    s1_gain_r <= ctrl.tap_gain;
  end

  // operand: current sample for zero delay, zero for never-written entries
  always_comb begin
    if (s1_fwd_r) begin
      op = sample;
    end else if (s1_live_r) begin
      op = $signed(rd_data);
    end else begin
      op = '0;
    end
  end

  assign prod_nxt = PROD_W'(op) * PROD_W'($signed({1'b0, s1_gain_r}));

  // stage 2: tap product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // full-precision accumulator
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      acc_r <= '0;
    end else if (s2_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // master gain
  assign total_nxt = TOTAL_W'(acc_r) * TOTAL_W'($signed({1'b0, mix_gain}));

  always_ff @(posedge clk) begin
    if (ctrl.master_en) begin
      total_r <= total_nxt;
    end
  end

  // floor shift then saturate to 16 bits
  assign q = total_r[TOTAL_W-1:FRAC_SH];

  always_comb begin
    if ((q[Q_W-1:SAMPLE_W-1] == '0) || (q[Q_W-1:SAMPLE_W-1] == '1)) begin
      result = q[SAMPLE_W-1:0];
    end else if (q[Q_W-1]) begin
      result = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  assign busy = s1_v_r | s2_v_r;

endmodule

>>> hw/rtl/multitap_delay_line.sv
// multitap delay: one item at a time; after an item is accepted the sequencer reads
// the active taps (up to TAPS, or none) from the ring, one tap per cycle, waits for
// the two-stage multiply pipeline to empty, applies the master gain and loads the
// output register; a new item is taken only after that, and only while the output side
// keeps up; the single memory read port and this sequence limit the item rate.
// synchronous active-low reset clears registers and pointer; a wrap flag masks entries not written since the last clear.
module multitap_delay_line #(
  parameter int TAPS  = mtd_pkg::TAPS_DEF,
  parameter int DEPTH = mtd_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [mtd_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mtd_pkg::SAMPLE_W-1:0]  out_sample,
  input  logic                                 cfg_we,
  input  logic        [mtd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [mtd_pkg::CFG_W-1:0]     cfg_wdata
);

  import mtd_pkg::*;

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int TCW = $clog2(TAPS + 1);

  state_t state_r, state_nxt;

  logic [BUFLEN_W-1:0] buffer_length_r;
  logic [NTAPS_W-1:0]  active_taps_r;
  logic [GAIN_W-1:0]   mix_gain_r;
  logic [DELAY_W-1:0]  tap_delay_r [TAPS];
  logic [GAIN_W-1:0]   tap_gain_r  [TAPS];
  logic                cfg_hit;

  logic [AW-1:0]       wp_r;
  logic                wrapped_r;
  logic [AW-1:0]       item_wp_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [TW-1:0]       tap_cnt_r, tap_cnt_nxt;

  logic [AW-1:0]       last;
  logic [TCW-1:0]      taps_eff;
  logic [DELAY_W-1:0]  dly_raw;
  logic [AW-1:0]       dly;
  logic [AW:0]         pos_wrap;
  logic [AW-1:0]       pos;
  logic                last_tap;
  logic                accept;

  mac_ctrl_t           ctrl;
  logic                mac_busy;
  logic signed [SAMPLE_W-1:0] mac_result;
  logic [SAMPLE_W-1:0] rd_data;

  logic                out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                out_load;

  // configuration decode: any listed register clears the ring
  always_comb begin
    unique case (cfg_index) inside
      REG_BUFFER_LENGTH, REG_ACTIVE_TAPS, REG_MIX_GAIN,
      REG_TAP0, REG_TAP1, REG_TAP2, REG_TAP3: cfg_hit = 1'b1;
      default:                                cfg_hit = 1'b0;
    endcase
  end

  // global configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_length_r <= '0;
      active_taps_r   <= '0;
      mix_gain_r      <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_BUFFER_LENGTH) begin
        buffer_length_r <= cfg_wdata[BUFLEN_W-1:0];
      end
      if (cfg_index == REG_ACTIVE_TAPS) begin
        active_taps_r <= cfg_wdata[NTAPS_W-1:0];
      end
      if (cfg_index == REG_MIX_GAIN) begin
        mix_gain_r <= cfg_wdata[GAIN_W-1:0];
      end
    end
  end

  // per-tap delay and gain registers
  for (genvar t = 0; t < TAPS; t++) begin : g_tap
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tap_delay_r[t] <= '0;
        tap_gain_r[t]  <= '0;
      end else if (cfg_we && (cfg_index == CFG_IDX_W'(REG_TAP0 + t))) begin
        tap_delay_r[t] <= cfg_wdata[TAP_DLY_LSB +: DELAY_W];
        tap_gain_r[t]  <= cfg_wdata[GAIN_W-1:0];
      end
    end
  end

  // effective ring end and tap count
  assign last = (buffer_length_r > BUFLEN_W'(DEPTH - 1)) ? AW'(DEPTH - 1)
                                                         : AW'(buffer_length_r);
  assign taps_eff = (active_taps_r > NTAPS_W'(TAPS)) ? TCW'(TAPS) : TCW'(active_taps_r);

  // tap read address: delay clamped to ring end, modulo ring size
  assign dly_raw  = tap_delay_r[tap_cnt_r];
  assign dly      = (dly_raw > DELAY_W'(last)) ? last : AW'(dly_raw);
  assign pos_wrap = {1'b0, item_wp_r} + {1'b0, last} + (AW + 1)'(1) - {1'b0, dly};
  assign pos      = (dly <= item_wp_r) ? (item_wp_r - dly) : pos_wrap[AW-1:0];
  assign last_tap = (TCW'(tap_cnt_r) + TCW'(1)) == taps_eff;

  assign accept   = in_valid && in_ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // write pointer and wrap flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
    end else if (cfg_we && cfg_hit) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
    end else if (accept) begin
      if (wp_r == last) begin
        wp_r      <= '0;
        wrapped_r <= 1'b1;
      end else begin
        wp_r <= wp_r + AW'(1);
      end
    end
  end

  // item holding registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_wp_r <= wp_r;
      sample_r  <= in_sample;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      tap_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      tap_cnt_r <= tap_cnt_nxt;
    end
  end

  // sequencer next state and controls
  always_comb begin
    state_nxt     = state_r;
    tap_cnt_nxt   = tap_cnt_r;
    in_ready      = 1'b0;
    ctrl          = '0;
    ctrl.tap_gain = tap_gain_r[tap_cnt_r];
    ctrl.tap_fwd  = (dly == '0);
    ctrl.tap_live = wrapped_r || (pos < item_wp_r);
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.start  = 1'b1;
          tap_cnt_nxt = '0;
          state_nxt   = (taps_eff == '0) ? S_DRAIN : S_TAP;
        end
      end
      S_TAP: begin
        ctrl.tap_vld = 1'b1;
        tap_cnt_nxt  = tap_cnt_r + TW'(1);
        if (last_tap) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!mac_busy) begin
          ctrl.master_en = 1'b1;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sample ring: write on accept, one tap read per cycle
  mtd_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (accept),
    .waddr(wp_r),
    .wdata(in_sample),
    .re   (ctrl.tap_vld),
    .raddr(pos),
    .rdata(rd_data)
  );

  // tap multiply-accumulate and master gain
  mtd_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .sample  (sample_r),
    .rd_data (rd_data),
    .mix_gain(mix_gain_r),
    .busy    (mac_busy),
    .result  (mac_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= mac_result;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // write pointer stays inside the ring
  a_wp_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= last)
    else $error("write pointer beyond ring end");

  // master gain only after the tap pipeline has emptied
  a_done_idle_mac: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> !mac_busy)
    else $error("tap pipeline busy at result");

  // an accepted item always starts the sequence
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("accepted item not processed");

endmodule

>>> sim/tb_multitap_delay_line.sv
`timescale 1ns / 1ps

module tb_multitap_delay_line;
  import mtd_pkg::*;

  localparam int TAP_TOTAL  = TAPS_DEF;
  localparam int RING_DEPTH = DEPTH_DEF;
  localparam int IDLE_PCT   = 22;
  localparam int RANDOM_ITEMS = 1150;
  // index past the end of the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // mirror of the block's registers and sample ring
  logic [BUFLEN_W-1:0] buf_len;
  logic [NTAPS_W-1:0] tap_count;
  logic [GAIN_W-1:0] out_gain;
  logic [CFG_W-1:0] tap_word [TAP_TOTAL];
  logic signed [SAMPLE_W-1:0] ring [RING_DEPTH];
  int unsigned wr_pos;

  logic signed [SAMPLE_W-1:0] expected_mix [$];
  logic signed [SAMPLE_W-1:0] mix_want;
  int error_count = 0;
  bit no_stall = 1'b0;
  int random_sent = 0;

  multitap_delay_line i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic clear_ring();
    foreach (ring[k]) ring[k] = '0;
    wr_pos = 0;
  endtask

  // register write as seen by the mirror; unknown index leaves everything alone
  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      REG_BUFFER_LENGTH: buf_len = val[BUFLEN_W-1:0];
      REG_ACTIVE_TAPS:   tap_count = val[NTAPS_W-1:0];
      REG_MIX_GAIN:      out_gain = val[GAIN_W-1:0];
      REG_TAP0:          tap_word[0] = val;
      REG_TAP1:          tap_word[1] = val;
      REG_TAP2:          tap_word[2] = val;
      REG_TAP3:          tap_word[3] = val;
      default:           return;
    endcase
    clear_ring();
  endtask

  // write the new sample, mix the taps, floor and saturate
  function automatic logic signed [SAMPLE_W-1:0] mix_sample(input logic signed [SAMPLE_W-1:0] s);
    int unsigned last, size, taps, dly, pos;
    longint acc, total, q;
    last = buf_len;
    if (last > RING_DEPTH - 1) last = RING_DEPTH - 1;
    size = last + 1;
    if (wr_pos > last) wr_pos = 0;
    ring[wr_pos] = s;
    taps = (tap_count > TAP_TOTAL) ? TAP_TOTAL : tap_count;
    acc = 0;
    for (int i = 0; i < taps; i++) begin
      dly = tap_word[i][TAP_DLY_LSB +: DELAY_W];
      if (dly > last) dly = last;
      pos = (wr_pos + size - dly) % size;
      acc += longint'(ring[pos]) * longint'(tap_word[i][GAIN_W-1:0]);
    end
    total = acc * longint'(out_gain);
    q = total >>> FRAC_SH;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    wr_pos = wr_pos + 1;
    if (wr_pos > last) wr_pos = 0;
    return q[SAMPLE_W-1:0];
  endfunction

  function automatic logic [CFG_W-1:0] tap_cfg(input int unsigned dly, input int unsigned gain);
    return {dly[DELAY_W-1:0], gain[GAIN_W-1:0]};
  endfunction

  // one item on the input channel; valid stays up until the caller idles
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    if (!no_stall && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_mix.push_back(mix_sample(s));
  endtask

  // drop valid and wait for every pending item to come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_mix.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      case ($urandom_range(3))
        0: return 16'sh7fff;
        1: return 16'sh8000;
        2: return 16'sh0000;
        default: return 16'shffff;
      endcase
    end
    if (pick < 35) return $signed(16'($urandom_range(511))) - 16'sd256;
    return 16'($urandom);
  endfunction

  // narrow registers get junk above their width
  function automatic logic [CFG_W-1:0] with_junk(input int unsigned val, input int width);
    logic [CFG_W-1:0] w;
    w = CFG_W'($urandom);
    w = (w << width) | CFG_W'(val);
    return w;
  endfunction

  task automatic randomize_settings();
    int unsigned pick, blen, dly, gain, mg;
    pick = $urandom_range(99);
    if (pick < 10) blen = $urandom_range(1) ? 4095 : 0;
    else if (pick < 30) blen = $urandom_range(4095);
    else blen = $urandom_range(63);
    write_reg(REG_BUFFER_LENGTH, with_junk(blen, BUFLEN_W));
    write_reg(REG_ACTIVE_TAPS, with_junk($urandom_range(7), NTAPS_W));
    pick = $urandom_range(99);
    if (pick < 10) mg = $urandom_range(1) ? 16'hffff : 0;
    else if (pick < 45) mg = $urandom_range(16'h4000);
    else mg = $urandom_range(16'hffff);
    write_reg(REG_MIX_GAIN, with_junk(mg, GAIN_W));
    for (int i = 0; i < TAP_TOTAL; i++) begin
      if ($urandom_range(99) < 75) dly = $urandom_range(blen + 2);
      else dly = $urandom_range(4095);
      if (dly > 4095) dly = 4095;
      gain = ($urandom_range(99) < 15) ? 16'h4000 : $urandom_range(16'hffff);
      write_reg(cfg_reg_t'(REG_TAP0 + i), tap_cfg(dly, gain));
    end
    // sometimes rewrite the length last, it must clear again
    if ($urandom_range(3) == 0) write_reg(REG_BUFFER_LENGTH, CFG_W'(blen));
  endtask

  task automatic run_random_phase(input int n);
    wait_idle();
    randomize_settings();
    repeat (n) begin
      send_sample(rand_sample());
      random_sent++;
    end
  endtask

  // everything zero after reset, so all outputs are silent
  task automatic test_reset_state();
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh1234);
    wait_idle();
  endtask

  // mixed delays, one clamped, then saturation and floor rounding
  task automatic test_directed_mix();
    logic signed [SAMPLE_W-1:0] seq [8] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff,
                                             16'sh0001, 16'sh3039, 16'shcfc7, 16'sh7fff};
    write_reg(REG_BUFFER_LENGTH, 7);
    write_reg(REG_ACTIVE_TAPS, 4);
    write_reg(REG_MIX_GAIN, 16'h4000);
    write_reg(REG_TAP0, tap_cfg(0, 16'h4000));
    write_reg(REG_TAP1, tap_cfg(3, 16'hffff));
    write_reg(REG_TAP2, tap_cfg(9, 16'h2000));
    write_reg(REG_TAP3, tap_cfg(7, 16'h0001));
    foreach (seq[k]) send_sample(seq[k]);
    wait_idle();
    // full gains everywhere: hard saturation both ways
    write_reg(REG_MIX_GAIN, 16'hffff);
    for (int i = 0; i < TAP_TOTAL; i++) write_reg(cfg_reg_t'(REG_TAP0 + i), tap_cfg(0, 16'hffff));
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'shffff);
    wait_idle();
    // tiny gains: floor toward minus infinity
    write_reg(REG_ACTIVE_TAPS, 1);
    write_reg(REG_MIX_GAIN, 16'h0001);
    write_reg(REG_TAP0, tap_cfg(0, 16'h0001));
    send_sample(16'shffff);
    send_sample(16'sh0001);
    wait_idle();
  endtask

  // one-entry ring: every tap hears the current input
  task automatic test_zero_length();
    write_reg(REG_BUFFER_LENGTH, 0);
    write_reg(REG_ACTIVE_TAPS, 2);
    write_reg(REG_MIX_GAIN, 16'h4000);
    write_reg(REG_TAP0, tap_cfg(5, 16'h2000));
    write_reg(REG_TAP1, tap_cfg(4095, 16'h1000));
    send_sample(16'sh4000);
    send_sample(16'shc000);
    send_sample(16'sh0007);
    wait_idle();
  endtask

  // tap count above the tap total, and a write to an unused index
  task automatic test_tap_limit();
    write_reg(REG_BUFFER_LENGTH, 4095);
    write_reg(REG_TAP0, tap_cfg(0, 16'h1000));
    write_reg(REG_TAP1, tap_cfg(1, 16'h1000));
    write_reg(REG_TAP2, tap_cfg(2, 16'h1000));
    write_reg(REG_TAP3, tap_cfg(4095, 16'h1000));
    write_reg(REG_MIX_GAIN, 16'h4000);
    write_reg(REG_ACTIVE_TAPS, 7);
    send_sample(16'sh1000);
    send_sample(16'sh2000);
    wait_idle();
    // ring must survive this write
    write_reg(REG_UNUSED, 28'hfffffff);
    send_sample(16'sh0300);
    wait_idle();
    write_reg(REG_ACTIVE_TAPS, 5);
    send_sample(16'sh7000);
    send_sample(16'sh9000);
    wait_idle();
  endtask

  task automatic test_random_mix();
    while (random_sent < RANDOM_ITEMS - 150) run_random_phase($urandom_range(30, 70));
    wait_idle();
  endtask

  // both sides run flat out
  task automatic test_back_to_back();
    wait_idle();
    no_stall = 1'b1;
    run_random_phase(150);
    wait_idle();
    no_stall = 1'b0;
  endtask

  // output side: random stalls and the result check
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_mix.size() == 0) begin
        report_mismatch($sformatf("unexpected item out_sample=%0d", out_sample));
      end else begin
        mix_want = expected_mix.pop_front();
        if (out_sample !== mix_want)
          report_mismatch($sformatf("out_sample got %0d want %0d", out_sample, mix_want));
      end
    end
    out_ready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    buf_len   = '0;
    tap_count = '0;
    out_gain  = '0;
    foreach (tap_word[k]) tap_word[k] = '0;
    clear_ring();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed_mix();
    test_zero_length();
    test_tap_limit();
    test_random_mix();
    test_back_to_back();
    wait_idle();
    repeat (20) @(posedge clk);
    if (expected_mix.size() != 0)
      report_mismatch($sformatf("%0d items never came out", expected_mix.size()));
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/mtd_pkg.sv
hw/rtl/mtd_ram.sv
hw/rtl/mtd_mac.sv
hw/rtl/multitap_delay_line.sv
sim/tb_multitap_delay_line.sv
